### hdl/npc_pkg.sv
`timescale 1ns / 1ps
package npc_pkg;

  localparam int COLOR_W = 24;
  localparam int DIST_W  = 18;
  localparam int ADDR_W  = 4;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] REG_USED_COUNT    = 2'd0;
  localparam logic [1:0] REG_LOCKED_ENABLE = 2'd1;
  localparam logic [1:0] REG_LOCKED_INDEX  = 2'd2;

  localparam logic [8:0] USED_COUNT_RESET = 9'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } npc_state_t;

  // pend: a palette read is in flight; qual: that entry takes part in the search
  typedef struct packed {
    logic pend;
    logic qual;
  } npc_tag_t;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    begin
      d = (a > b) ? (a - b) : (b - a);
      sq_diff = 16'(d * d);
    end
  endfunction

endpackage

### hdl/nearest_palette_color_search.sv
`timescale 1ns / 1ps
// Nearest palette color search. A write item (func 0) stores an RGB888 color
// in one palette slot and busy stays low. A query (func 1) raises busy,
// reads one palette slot per cycle through a single memory read port and one
// shared distance/compare unit, scans min(used_count, PALETTE_DEPTH) slots,
// and strobes out_valid with out_nearest_index once the reads in flight have
// drained. The result is shown for exactly one cycle and cannot be stalled; a
// new start may be taken in that same cycle. Slots that a query reads must
// have been written before.
module nearest_palette_color_search #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       start,
  output logic                       busy,
  input  logic                       in_func,
  input  logic [7:0]                 in_entry_index,
  input  logic [7:0]                 in_red,
  input  logic [7:0]                 in_green,
  input  logic [7:0]                 in_blue,

  output logic                       out_valid,
  output logic [7:0]                 out_nearest_index,

  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [npc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int IDX_W  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);
  localparam int WIDE_W = (CNT_W > 9) ? CNT_W : 9;

  npc_pkg::npc_state_t state_r, state_nxt;

  logic [8:0]                  used_count_r;
  logic                        locked_enable_r;
  logic [7:0]                  locked_index_r;
  logic [npc_pkg::COLOR_W-1:0] color_r;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [CNT_W-1:0]            limit_r, limit_nxt;
  npc_pkg::npc_tag_t           tag1_r, tag1_nxt;
  logic [IDX_W-1:0]            idx1_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_idx_r;

  logic                        accept, cfg_wr;
  logic                        query_go;
  logic                        issue;
  logic                        locked_hit;
  logic [WIDE_W-1:0]           ent_wide, cnt_wide, lock_wide, used_wide;
  logic                        wr_en;
  logic [npc_pkg::COLOR_W-1:0] rd_data;
  logic                        pend2;
  logic [IDX_W-1:0]            best_idx;

  assign accept   = start && !busy;
  assign query_go = accept && (in_func == npc_pkg::FUNC_QUERY);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  assign ent_wide  = WIDE_W'(in_entry_index);
  assign cnt_wide  = WIDE_W'(cnt_r);
  assign lock_wide = WIDE_W'(locked_index_r);
  assign used_wide = WIDE_W'(used_count_r);

  assign wr_en = accept && (in_func == npc_pkg::FUNC_WRITE)
              && (ent_wide < WIDE_W'(PALETTE_DEPTH));

  assign limit_nxt = (used_wide > WIDE_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH)
                                                          : CNT_W'(used_count_r);

  assign issue      = (state_r == npc_pkg::ST_SCAN) && (cnt_r < limit_r);
  assign locked_hit = locked_enable_r && (cnt_wide == lock_wide);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_count_r    <= npc_pkg::USED_COUNT_RESET;
      locked_enable_r <= 1'b0;
      locked_index_r  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        npc_pkg::REG_USED_COUNT:    used_count_r    <= pwdata[8:0];
        npc_pkg::REG_LOCKED_ENABLE: locked_enable_r <= pwdata[0];
        npc_pkg::REG_LOCKED_INDEX:  locked_index_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      npc_pkg::REG_USED_COUNT:    prdata = 32'(used_count_r);
      npc_pkg::REG_LOCKED_ENABLE: prdata = 32'(locked_enable_r);
      npc_pkg::REG_LOCKED_INDEX:  prdata = 32'(locked_index_r);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= npc_pkg::ST_IDLE;
      cnt_r       <= '0;
      limit_r     <= '0;
      tag1_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tag1_r      <= tag1_nxt;
      out_valid_r <= out_valid_nxt;
      if (query_go) begin
        limit_r <= limit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= cnt_r[IDX_W-1:0];
    if (query_go) begin
      color_r <= {in_red, in_green, in_blue};
    end
    if (out_valid_nxt) begin
      out_idx_r <= 8'(best_idx);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    tag1_nxt.pend = issue;
    tag1_nxt.qual = issue && !locked_hit;
    unique case (state_r)
      npc_pkg::ST_IDLE: begin
        if (query_go) begin
          cnt_nxt   = '0;
          state_nxt = npc_pkg::ST_SCAN;
        end
      end
      npc_pkg::ST_SCAN: begin
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          state_nxt = npc_pkg::ST_DRAIN;
        end
      end
      npc_pkg::ST_DRAIN: begin
        if (!tag1_r.pend && !pend2) begin
          out_valid_nxt = 1'b1;
          state_nxt     = npc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = npc_pkg::ST_IDLE;
    endcase
  end

  assign busy              = (state_r != npc_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_nearest_index = out_idx_r;

  npc_palette_mem #(
    .DEPTH (PALETTE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ent_wide[IDX_W-1:0]),
    .wr_data ({in_red, in_green, in_blue}),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  npc_dist_unit #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (query_go),
    .color    (color_r),
    .entry    (rd_data),
    .tag_in   (tag1_r),
    .idx_in   (idx1_r),
    .pend_out (pend2),
    .best_idx (best_idx)
  );

endmodule

### hdl/npc_palette_mem.sv
`timescale 1ns / 1ps
module npc_palette_mem #(
  parameter int DEPTH = 256,
  parameter int IDX_W = 8
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [npc_pkg::COLOR_W-1:0] wr_data,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [npc_pkg::COLOR_W-1:0] rd_data
);

  logic [npc_pkg::COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/npc_dist_unit.sv
`timescale 1ns / 1ps
module npc_dist_unit #(
  parameter int IDX_W = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic [npc_pkg::COLOR_W-1:0] color,
  input  logic [npc_pkg::COLOR_W-1:0] entry,
  input  npc_pkg::npc_tag_t           tag_in,
  input  logic [IDX_W-1:0]            idx_in,
  output logic                        pend_out,
  output logic [IDX_W-1:0]            best_idx
);

  logic [npc_pkg::DIST_W-1:0] dist_nxt, dist_r;
  npc_pkg::npc_tag_t          tag_r;
  logic [IDX_W-1:0]           idx_r;
  logic [npc_pkg::DIST_W-1:0] best_dist_r;
  logic [IDX_W-1:0]           best_idx_r;
  logic                       found_r;
  logic                       take;

  assign dist_nxt = npc_pkg::DIST_W'(npc_pkg::sq_diff(entry[23:16], color[23:16]))
                  + npc_pkg::DIST_W'(npc_pkg::sq_diff(entry[15:8],  color[15:8]))
                  + npc_pkg::DIST_W'(npc_pkg::sq_diff(entry[7:0],   color[7:0]));

  // strict compare: lowest index wins a tie
  assign take = tag_r.qual && (!found_r || (dist_r < best_dist_r));

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    idx_r  <= idx_in;
    if (take) begin
      best_dist_r <= dist_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r      <= '0;
      found_r    <= 1'b0;
      best_idx_r <= '0;
    end else begin
      tag_r <= tag_in;
      if (clear) begin
        found_r    <= 1'b0;
        best_idx_r <= '0;
      end else if (take) begin
        found_r    <= 1'b1;
        best_idx_r <= idx_r;
      end
    end
  end

  assign pend_out = tag_r.pend;
  assign best_idx = best_idx_r;

endmodule

### sim/tb_nearest_palette_color_search.sv
`timescale 1ns / 1ps
module tb_nearest_palette_color_search;
  import npc_pkg::*;

  localparam int DEPTH       = 256;
  localparam int STALL_LIMIT = 5000;
  localparam int SEGMENTS    = 10;
  localparam int SEG_ITEMS   = 175;
  localparam int SETTLE      = 8;

  // address past the last register, writes there must be dropped
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CFG,
    ROW_FILL
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        func;
    logic [7:0]  idx;
    logic [23:0] rgb;
    logic [1:0]  reg_id;
    logic [31:0] value;
    logic        has_want;
    logic [7:0]  want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        in_func = FUNC_WRITE;
  logic [7:0]  in_entry_index = '0;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;

  logic        busy;
  logic        out_valid;
  logic [7:0]  out_nearest_index;
  logic [31:0] prdata;
  logic        pready;

  nearest_palette_color_search #(.PALETTE_DEPTH(DEPTH)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_entry_index    (in_entry_index),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_nearest_index (out_nearest_index),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [23:0] pal_shadow [DEPTH];
  logic [8:0]  cnt_shadow = USED_COUNT_RESET;
  logic        lock_en_shadow = 1'b0;
  logic [7:0]  lock_idx_shadow = '0;
  logic [7:0]  nearest_q [$];
  logic [7:0]  want_idx;
  int          err_cnt = 0;
  int          stall_cnt = 0;
  int          idle_pct = 0;

  function automatic int unsigned chan_sq(input logic [7:0] a, input logic [7:0] b);
    int unsigned diff;
    diff = (a > b) ? (a - b) : (b - a);
    return diff * diff;
  endfunction

  function automatic logic [7:0] find_nearest(input logic [23:0] rgb);
    int unsigned lim;
    int unsigned best_dist;
    int unsigned cur_dist;
    int          best_i;
    logic [23:0] e;
    lim = (cnt_shadow > DEPTH) ? DEPTH : cnt_shadow;
    best_dist = 32'hFFFF_FFFF;
    best_i = 0;
    for (int i = 0; i < lim; i++) begin
      if (lock_en_shadow && i == lock_idx_shadow) continue;
      e = pal_shadow[i];
      cur_dist = chan_sq(e[23:16], rgb[23:16]) + chan_sq(e[15:8], rgb[15:8])
               + chan_sq(e[7:0], rgb[7:0]);
      if (cur_dist < best_dist) begin
        best_dist = cur_dist;
        best_i = i;
      end
    end
    return best_i[7:0];
  endfunction

  function automatic step_t mk_item(input logic func, input logic [7:0] idx,
                                    input logic [23:0] rgb, input logic has_want,
                                    input logic [7:0] want);
    step_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.func = func;
    r.idx = idx;
    r.rgb = rgb;
    r.has_want = has_want;
    r.want = want;
    return r;
  endfunction

  function automatic step_t mk_cfg(input logic [1:0] reg_id, input logic [31:0] value);
    step_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_id = reg_id;
    r.value = value;
    return r;
  endfunction

  task automatic send(input logic func, input logic [7:0] idx, input logic [23:0] rgb,
                      input logic has_want, input logic [7:0] want);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= func;
    in_entry_index <= idx;
    in_red <= rgb[23:16];
    in_green <= rgb[15:8];
    in_blue <= rgb[7:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    if (func == FUNC_WRITE) pal_shadow[idx] = rgb;
    else nearest_q.push_back(has_want ? want : find_nearest(rgb));
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (nearest_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] reg_id, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_id, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (reg_id)
      REG_USED_COUNT:    cnt_shadow = value[8:0];
      REG_LOCKED_ENABLE: lock_en_shadow = value[0];
      REG_LOCKED_INDEX:  lock_idx_shadow = value[7:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (nearest_q.size() == 0) begin
        $error("out_nearest_index: unexpected transfer, actual %0d", out_nearest_index);
        err_cnt++;
      end else begin
        want_idx = nearest_q.pop_front();
        if (out_nearest_index !== want_idx) begin
          $error("out_nearest_index mismatch: expected %0d, actual %0d",
                 want_idx, out_nearest_index);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pready) || !rst_n)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    step_t       rows [$];
    step_t       row;
    int          sel;
    int          lim;
    int          slot;
    logic        func;
    logic [8:0]  used;
    logic [23:0] rgb;

    rows.push_back(mk_item(FUNC_WRITE, 8'd0, 24'h000000, 1'b0, 8'd0));
    rows.push_back(mk_item(FUNC_WRITE, 8'd1, 24'hFFFFFF, 1'b0, 8'd0));
    rows.push_back(mk_item(FUNC_QUERY, 8'd0, 24'h000000, 1'b1, 8'd0));
    rows.push_back(mk_item(FUNC_QUERY, 8'd0, 24'hFFFFFF, 1'b1, 8'd1));
    rows.push_back(mk_item(FUNC_QUERY, 8'd0, 24'h7F7F7F, 1'b1, 8'd0));
    rows.push_back(mk_item(FUNC_QUERY, 8'hFF, 24'h808080, 1'b1, 8'd1));
    rows.push_back(mk_item(FUNC_WRITE, 8'd1, 24'h000000, 1'b0, 8'd0));
    // equal distances: lowest slot wins
    rows.push_back(mk_item(FUNC_QUERY, 8'd0, 24'h101010, 1'b1, 8'd0));
    rows.push_back(mk_cfg(REG_LOCKED_INDEX, 32'd0));
    rows.push_back(mk_cfg(REG_LOCKED_ENABLE, 32'd1));
    rows.push_back(mk_item(FUNC_QUERY, 8'd0, 24'h000000, 1'b1, 8'd1));
    // only searched slot is locked
    rows.push_back(mk_cfg(REG_USED_COUNT, 32'd1));
    rows.push_back(mk_item(FUNC_QUERY, 8'd0, 24'h123456, 1'b1, 8'd0));
    rows.push_back(mk_cfg(REG_USED_COUNT, 32'd0));
    rows.push_back(mk_cfg(REG_LOCKED_ENABLE, 32'd0));
    rows.push_back(mk_item(FUNC_QUERY, 8'd0, 24'hFF00FF, 1'b1, 8'd0));
    // gray ramp: slot i holds (i, i, i)
    row = '0;
    row.kind = ROW_FILL;
    rows.push_back(row);
    // count above depth saturates
    rows.push_back(mk_cfg(REG_USED_COUNT, 32'd511));
    rows.push_back(mk_item(FUNC_QUERY, 8'd0, 24'hC8C8C8, 1'b1, 8'd200));
    rows.push_back(mk_item(FUNC_QUERY, 8'd0, 24'hFFFFFF, 1'b1, 8'd255));
    rows.push_back(mk_cfg(REG_LOCKED_INDEX, 32'd255));
    rows.push_back(mk_cfg(REG_LOCKED_ENABLE, 32'd1));
    rows.push_back(mk_item(FUNC_QUERY, 8'd0, 24'hFFFFFF, 1'b1, 8'd254));
    rows.push_back(mk_cfg(REG_USED_COUNT, 32'd256));
    rows.push_back(mk_item(FUNC_QUERY, 8'd0, 24'h000000, 1'b1, 8'd0));
    rows.push_back(mk_cfg(REG_SPARE, 32'd0));
    rows.push_back(mk_item(FUNC_QUERY, 8'd0, 24'h808080, 1'b1, 8'd128));
    rows.push_back(mk_item(FUNC_WRITE, 8'd255, 24'hFF00AA, 1'b0, 8'd0));
    rows.push_back(mk_item(FUNC_QUERY, 8'd0, 24'hFF00AA, 1'b0, 8'd0));
    rows.push_back(mk_cfg(REG_LOCKED_ENABLE, 32'd0));
    rows.push_back(mk_item(FUNC_QUERY, 8'd0, 24'hFF00AA, 1'b1, 8'd255));
    rows.push_back(mk_cfg(REG_USED_COUNT, 32'd257));
    rows.push_back(mk_item(FUNC_QUERY, 8'd0, 24'hFEFEFE, 1'b1, 8'd254));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      case (row.kind)
        ROW_ITEM: send(row.func, row.idx, row.rgb, row.has_want, row.want);
        ROW_CFG: begin
          quiesce();
          cfg_write(row.reg_id, row.value);
        end
        default: begin
          for (int k = 0; k < DEPTH; k++)
            send(FUNC_WRITE, k[7:0], {3{k[7:0]}}, 1'b0, 8'd0);
        end
      endcase
    end

    for (int s = 0; s < SEGMENTS; s++) begin
      idle_pct = (s < 4) ? 7 : (s < 7) ? 48 : 0;
      quiesce();
      sel = $urandom_range(0, 99);
      if (sel < 55)      used = 9'($urandom_range(1, 16));
      else if (sel < 75) used = 9'($urandom_range(17, 64));
      else if (sel < 85) used = 9'($urandom_range(0, 2));
      else if (sel < 93) used = 9'd256;
      else               used = 9'($urandom_range(257, 511));
      lim = (used > DEPTH) ? DEPTH : used;
      cfg_write(REG_USED_COUNT, {23'd0, used});
      cfg_write(REG_LOCKED_ENABLE, 32'($urandom_range(0, 1)));
      if ($urandom_range(0, 99) < 70 && lim > 0)
        cfg_write(REG_LOCKED_INDEX, 32'($urandom_range(0, lim - 1)));
      else
        cfg_write(REG_LOCKED_INDEX, 32'($urandom_range(0, 255)));
      if (lim == 0) lim = 4;

      for (int n = 0; n < SEG_ITEMS; n++) begin
        if ($urandom_range(0, 149) == 0) quiesce();
        func = ($urandom_range(0, 99) < 45) ? FUNC_WRITE : FUNC_QUERY;
        slot = ($urandom_range(0, 99) < 80) ? $urandom_range(0, lim - 1)
                                            : $urandom_range(0, 255);
        sel = $urandom_range(0, 99);
        if (func == FUNC_WRITE) begin
          // a few repeated grays so that ties come up
          if (sel < 35) rgb = {3{8'($urandom_range(0, 5) * 51)}};
          else          rgb = 24'($urandom);
        end else begin
          if (sel < 30)      rgb = pal_shadow[slot];
          else if (sel < 50) rgb = pal_shadow[slot] ^ (24'($urandom) & 24'h030303);
          else if (sel < 60) rgb = {{8{$urandom_range(0, 1) == 1}},
                                    {8{$urandom_range(0, 1) == 1}},
                                    {8{$urandom_range(0, 1) == 1}}};
          else               rgb = 24'($urandom);
          slot = $urandom_range(0, 255);
        end
        send(func, slot[7:0], rgb, 1'b0, 8'd0);
      end
    end

    quiesce();
    repeat (20) @(posedge clk);
    if (nearest_q.size() != 0) begin
      $error("out_nearest_index: %0d expected transfers never arrived", nearest_q.size());
      err_cnt++;
    end
    if (err_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
